@@ hdl/ilha_pkg.sv @@
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared sizes, codes and types of the implicit-list heap allocator.
// ----------------------------------------------------------------------------
package ilha_pkg;

  // heap geometry; granule size must be a power of two
  localparam int unsigned HEAP_GRANULES = 8192;
  localparam int unsigned GRANULE_BYTES = 8;

  localparam int unsigned BYTES_W    = 16;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned GRAN_SHIFT = $clog2(GRANULE_BYTES);
  localparam int unsigned IDX_W      = $clog2(HEAP_GRANULES);
  localparam int unsigned SIZE_W     = $clog2(HEAP_GRANULES + 1);
  localparam int unsigned WALK_W     = SIZE_W + 1;
  localparam int unsigned NEED_W     = BYTES_W + 1 - GRAN_SHIFT;
  localparam int unsigned CMP_W      = ((NEED_W > WALK_W) ? NEED_W : WALK_W) + 1;
  localparam int unsigned FG_W       = ADDR_W - GRAN_SHIFT;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_FREE   = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOM  = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              used;
  } hdr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } hdr_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    hdr_t             data;
  } hdr_wr_t;

  // a zero size counts as one granule so the walk always advances
  function automatic logic [SIZE_W-1:0] hdr_size(hdr_t h);
    logic [SIZE_W-1:0] s;
    s = h.size;
    if (s == '0) begin
      s = SIZE_W'(1);
    end
    return s;
  endfunction

  // payload byte offset of the block whose header sits at granule g
  function automatic logic [ADDR_W-1:0] payload_of(logic [CMP_W-1:0] g);
    logic [CMP_W+GRAN_SHIFT-1:0] b;
    b = (CMP_W + GRAN_SHIFT)'(g + CMP_W'(1)) << GRAN_SHIFT;
    return b[ADDR_W-1:0];
  endfunction

endpackage

@@ hdl/ilha_if.sv @@
// ----------------------------------------------------------------------------
// ilha_if
// Request and response channels of the heap allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ilha_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [ilha_pkg::BYTES_W-1:0] request_bytes;
  logic [ilha_pkg::ADDR_W-1:0]  block_addr;

  modport source (output valid, kind, request_bytes, block_addr, input ready);
  modport sink   (input valid, kind, request_bytes, block_addr, output ready);
endinterface

interface ilha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ilha_pkg::ADDR_W-1:0] payload_addr;
  logic                        status;

  modport source (output valid, payload_addr, status, input ready);
  modport sink   (input valid, payload_addr, status, output ready);
endinterface

@@ hdl/ilha_hdr_mem.sv @@
// ----------------------------------------------------------------------------
// ilha_hdr_mem
// Header store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ilha_hdr_mem (
  input  logic              clk_i,
  input  ilha_pkg::hdr_rd_t rd_i,
  input  ilha_pkg::hdr_wr_t wr_i,
  output ilha_pkg::hdr_t    rdata_o
);

  ilha_pkg::hdr_t mem [ilha_pkg::HEAP_GRANULES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_o <= mem[rd_i.addr];
    end
  end

endmodule

@@ hdl/implicit_list_heap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_core
// First-fit heap allocator over an implicit list of block headers.
// ----------------------------------------------------------------------------
// Requests arrive on req_i: kind selects allocate (request_bytes payload bytes)
// or free (block_addr payload offset). Every request gives one response on
// rsp_o: the granted payload offset and a status (done or out of memory).
// Free requests and failed allocations answer with payload offset zero.
// One request is in work at a time, so the latency is also the request spacing.
// A free: header read in the transfer cycle, header write (FREE_WR), then
// response load (RESP). An allocation walks the headers from granule 0: a
// read (ALLOC_RD) and an evaluation (ALLOC_HDR) per header, a successor check
// (ALLOC_NXT) past a free block too small, which merges a free successor and
// evaluates again (ALLOC_EVAL), a split (SPLIT), then the response load (RESP),
// after a last ALLOC_RD when the walk reaches the heap top. The walk length
// depends on the heap contents and is set by the single read port of the
// header memory, with registered read data. The response sits in an output
// register, so a new request is taken while an earlier response still waits;
// when the receiver stalls and the output register is full, the finished
// result waits in the block and no further request is taken until it moves out.
// Reset empties the heap (top of heap back to granule 0) and drops any
// pending response; the header memory is not cleared, since a header is
// always written before it is read.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilha_req_if.sink   req_i,
  ilha_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_WR,
    ST_ALLOC_RD,
    ST_ALLOC_HDR,
    ST_ALLOC_NXT,
    ST_ALLOC_EVAL,
    ST_SPLIT,
    ST_RESP
  } state_e;

  state_e                            state_q;
  logic [ilha_pkg::WALK_W-1:0]       cur_q;
  logic [ilha_pkg::SIZE_W-1:0]       top_q;
  logic [ilha_pkg::NEED_W-1:0]       need_q;
  logic [ilha_pkg::SIZE_W-1:0]       size_q;
  logic [ilha_pkg::IDX_W-1:0]        free_idx_q;
  logic                              free_ok_q;
  logic [ilha_pkg::ADDR_W-1:0]       res_payload_q;
  logic                              res_status_q;
  logic                              out_valid_q;
  logic [ilha_pkg::ADDR_W-1:0]       out_payload_q;
  logic                              out_status_q;

  ilha_pkg::hdr_rd_t                 rd;
  ilha_pkg::hdr_wr_t                 wr;
  ilha_pkg::hdr_t                    rd_hdr;

  logic                              req_xfer;
  logic [ilha_pkg::NEED_W-1:0]       need_c;
  logic [ilha_pkg::FG_W-1:0]         free_gidx;
  logic [ilha_pkg::CMP_W-1:0]        free_idx_c;
  logic                              free_ok_c;

  logic [ilha_pkg::SIZE_W-1:0]       eval_size;
  logic                              eval_free;
  logic                              eval_fit;
  logic [ilha_pkg::WALK_W-1:0]       eval_next;
  logic                              next_in_heap;
  logic                              cur_in_heap;
  logic                              tail_fits;
  logic [ilha_pkg::SIZE_W-1:0]       merged;
  logic [ilha_pkg::WALK_W-1:0]       split_at;
  logic                              out_free;

  ilha_hdr_mem u_hdr_mem (
    .clk_i   (clk_i),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (rd_hdr)
  );

  assign req_i.ready        = (state_q == ST_IDLE);
  assign req_xfer           = req_i.valid && req_i.ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.payload_addr = out_payload_q;
  assign rsp_o.status       = out_status_q;
  assign out_free           = !out_valid_q || rsp_o.ready;

  // granules for payload plus header, rounded up
  assign need_c = ilha_pkg::NEED_W'(
      ({1'b0, req_i.request_bytes} + (ilha_pkg::BYTES_W + 1)'(2 * ilha_pkg::GRANULE_BYTES - 1))
      >> ilha_pkg::GRAN_SHIFT);

  assign free_gidx  = req_i.block_addr[ilha_pkg::ADDR_W-1:ilha_pkg::GRAN_SHIFT];
  assign free_idx_c = ilha_pkg::CMP_W'(free_gidx) - ilha_pkg::CMP_W'(1);
  assign free_ok_c  = (req_i.block_addr[ilha_pkg::GRAN_SHIFT-1:0] == '0)
                   && (free_gidx != '0)
                   && (free_idx_c < ilha_pkg::CMP_W'(top_q));

  // walk step: evaluates a header fresh from memory or a merged one held locally
  assign eval_size    = (state_q == ST_ALLOC_HDR) ? ilha_pkg::hdr_size(rd_hdr) : size_q;
  assign eval_free    = (state_q == ST_ALLOC_HDR) ? !rd_hdr.used : 1'b1;
  assign eval_fit     = ilha_pkg::CMP_W'(eval_size) >= ilha_pkg::CMP_W'(need_q);
  assign eval_next    = cur_q + ilha_pkg::WALK_W'(eval_size);
  assign next_in_heap = eval_next < ilha_pkg::WALK_W'(top_q);
  assign cur_in_heap  = cur_q < ilha_pkg::WALK_W'(top_q);
  assign tail_fits    = (ilha_pkg::CMP_W'(top_q) + ilha_pkg::CMP_W'(need_q))
                     <= ilha_pkg::CMP_W'(ilha_pkg::HEAP_GRANULES);
  assign merged       = size_q + ilha_pkg::hdr_size(rd_hdr);
  assign split_at     = cur_q + ilha_pkg::WALK_W'(need_q);

  always_comb begin
    rd = '0;
    wr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_xfer && req_i.kind == ilha_pkg::KIND_FREE && free_ok_c) begin
          rd.en   = 1'b1;
          rd.addr = free_idx_c[ilha_pkg::IDX_W-1:0];
        end
      end
      ST_FREE_WR: begin
        if (free_ok_q) begin
          wr.en        = 1'b1;
          wr.addr      = free_idx_q;
          wr.data.size = rd_hdr.size;
          wr.data.used = 1'b0;
        end
      end
      ST_ALLOC_RD: begin
        if (cur_in_heap) begin
          rd.en   = 1'b1;
          rd.addr = cur_q[ilha_pkg::IDX_W-1:0];
        end else if (tail_fits) begin
          wr.en        = 1'b1;
          wr.addr      = top_q[ilha_pkg::IDX_W-1:0];
          wr.data.size = ilha_pkg::SIZE_W'(need_q);
          wr.data.used = 1'b1;
        end
      end
      ST_ALLOC_HDR, ST_ALLOC_EVAL: begin
        if (eval_free && eval_fit) begin
          wr.en        = 1'b1;
          wr.addr      = cur_q[ilha_pkg::IDX_W-1:0];
          wr.data.size = ilha_pkg::SIZE_W'(need_q);
          wr.data.used = 1'b1;
        end else if (eval_free && next_in_heap) begin
          rd.en   = 1'b1;
          rd.addr = eval_next[ilha_pkg::IDX_W-1:0];
        end
      end
      ST_ALLOC_NXT: begin
        // coalesce with a free successor
        if (!rd_hdr.used) begin
          wr.en        = 1'b1;
          wr.addr      = cur_q[ilha_pkg::IDX_W-1:0];
          wr.data.size = merged;
          wr.data.used = 1'b0;
        end
      end
      ST_SPLIT: begin
        wr.en        = 1'b1;
        wr.addr      = split_at[ilha_pkg::IDX_W-1:0];
        wr.data.size = size_q - ilha_pkg::SIZE_W'(need_q);
        wr.data.used = 1'b0;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a result waiting in ST_RESP reloads the output register instead
      if (out_valid_q && rsp_o.ready && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_xfer) begin
            need_q        <= need_c;
            cur_q         <= '0;
            free_idx_q    <= free_idx_c[ilha_pkg::IDX_W-1:0];
            free_ok_q     <= free_ok_c;
            res_payload_q <= '0;
            res_status_q  <= ilha_pkg::STATUS_DONE;
            state_q       <= (req_i.kind == ilha_pkg::KIND_FREE) ? ST_FREE_WR : ST_ALLOC_RD;
          end
        end
        ST_FREE_WR: begin
          state_q <= ST_RESP;
        end
        ST_ALLOC_RD: begin
          if (cur_in_heap) begin
            state_q <= ST_ALLOC_HDR;
          end else if (tail_fits) begin
            // extend the heap top
            res_payload_q <= ilha_pkg::payload_of(ilha_pkg::CMP_W'(top_q));
            top_q         <= top_q + ilha_pkg::SIZE_W'(need_q);
            state_q       <= ST_RESP;
          end else begin
            res_status_q <= ilha_pkg::STATUS_OOM;
            state_q      <= ST_RESP;
          end
        end
        ST_ALLOC_HDR, ST_ALLOC_EVAL: begin
          size_q <= eval_size;
          if (eval_free && eval_fit) begin
            res_payload_q <= ilha_pkg::payload_of(ilha_pkg::CMP_W'(cur_q));
            state_q <= (ilha_pkg::CMP_W'(eval_size) > ilha_pkg::CMP_W'(need_q)) ? ST_SPLIT
                                                                                : ST_RESP;
          end else if (eval_free && next_in_heap) begin
            state_q <= ST_ALLOC_NXT;
          end else begin
            cur_q   <= eval_next;
            state_q <= ST_ALLOC_RD;
          end
        end
        ST_ALLOC_NXT: begin
          if (!rd_hdr.used) begin
            size_q  <= merged;
            state_q <= ST_ALLOC_EVAL;
          end else begin
            cur_q   <= cur_q + ilha_pkg::WALK_W'(size_q);
            state_q <= ST_ALLOC_RD;
          end
        end
        ST_SPLIT: begin
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_payload_q <= res_payload_q;
            out_status_q  <= res_status_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ilha_pkg::CMP_W'(top_q) <= ilha_pkg::CMP_W'(ilha_pkg::HEAP_GRANULES))
    else $error("heap top beyond heap capacity");

  a_rd_wr_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd.en && wr.en && rd.addr == wr.addr))
    else $error("read and write of the same header in one cycle");

  a_walk_rd_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd.en && state_q != ST_IDLE) |-> (ilha_pkg::WALK_W'(rd.addr) < ilha_pkg::WALK_W'(top_q)))
    else $error("walk reads a header above the heap top");

  a_oom_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ilha_pkg::STATUS_OOM) |-> (out_payload_q == '0))
    else $error("failed allocation carries a payload offset");

  a_resp_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not moved to the output register");

endmodule
